>>> src/gcts_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and sizes for the graph coloring tabu search block
// no dependencies
package gcts_pkg;

  localparam int MAX_VERTICES = 512;
  localparam int MAX_COLORS   = 64;
  localparam int MAX_TIES     = 2048;

  localparam int CONFLICT_W  = 17;
  localparam int COUNT_W     = 10;
  localparam int TABU_W      = 32;
  localparam int TENURE_SPAN = 10;
  localparam logic [COUNT_W-1:0]    COUNT_MAX    = '1;
  localparam logic [CONFLICT_W-1:0] CONFLICT_MAX = '1;

  localparam int IN_W  = 48;
  localparam int OUT_W = 104;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_COLOR_COUNT  = 1'b1;

  typedef enum logic [2:0] {
    MODE_LOAD_EDGE = 3'd0,
    MODE_SET_COLOR = 3'd1,
    MODE_PREPARE   = 3'd2,
    MODE_ITERATE   = 3'd3,
    MODE_READ      = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_MOVE  = 2'd1,
    STATUS_DEG_FULL = 2'd2,
    STATUS_RANGE    = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    ST_INIT, ST_IDLE, ST_DISPATCH,
    ST_E_RDB, ST_E_CHK, ST_E_WRB, ST_R_RD,
    ST_P_CLR, ST_P_VTX, ST_P_VTX2, ST_P_NB, ST_P_NB2, ST_P_NB3, ST_P_NB4, ST_P_FIN,
    ST_I_START, ST_I_VTX, ST_I_VTX2, ST_I_VTX3, ST_I_COL, ST_I_COL2, ST_I_DECIDE,
    ST_I_MOD, ST_I_TIE, ST_I_TIE2, ST_I_APPLY, ST_I_TABU, ST_I_TABU2,
    ST_I_NB, ST_I_NB2, ST_I_NB3, ST_I_NB4, ST_I_NB5,
    ST_DONE
  } state_e;

  typedef struct packed {
    state_e step;
    logic   accept;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       bad;
    logic       full;
    logic       sweep_end;
    logic       i_end;
    logic       k_end;
    logic       u_out;
    logic       here_zero;
    logic       j_end;
    logic       j_is_ci;
    logic       no_move;
    logic       mod_end;
  } sts_t;

  typedef struct packed {
    logic [31:0]           iter;
    logic                  solved;
    logic [5:0]            cout;
    logic [9:0]            delta;
    logic [5:0]            mc;
    logic [8:0]            mv;
    logic [CONFLICT_W-1:0] best;
    logic [CONFLICT_W-1:0] conflict;
    logic [1:0]            status;
  } res_t;

endpackage

>>> src/gcts_ctrl.sv
`timescale 1ns / 1ps
// sequencer for the tabu search block: one state per datapath step
// depends on gcts_pkg
module gcts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  input  logic             out_free_i,
  input  gcts_pkg::sts_t   sts_i,
  output gcts_pkg::cmd_t   cmd_o,
  output logic             s_tready_o
);

  gcts_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gcts_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o.step     = state_q;
    cmd_o.accept   = 1'b0;
    cmd_o.out_load = 1'b0;
    s_tready_o     = 1'b0;
    case (state_q)
      gcts_pkg::ST_INIT: if (sts_i.sweep_end) state_d = gcts_pkg::ST_IDLE;
      gcts_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          state_d = gcts_pkg::ST_DISPATCH;
        end
      end
      gcts_pkg::ST_DISPATCH: begin
        case (sts_i.mode)
          gcts_pkg::MODE_LOAD_EDGE:
            state_d = sts_i.bad ? gcts_pkg::ST_DONE : gcts_pkg::ST_E_RDB;
          gcts_pkg::MODE_PREPARE: state_d = gcts_pkg::ST_P_CLR;
          gcts_pkg::MODE_ITERATE: state_d = gcts_pkg::ST_I_START;
          gcts_pkg::MODE_READ:
            state_d = sts_i.bad ? gcts_pkg::ST_DONE : gcts_pkg::ST_R_RD;
          default: state_d = gcts_pkg::ST_DONE;
        endcase
      end
      gcts_pkg::ST_E_RDB: state_d = gcts_pkg::ST_E_CHK;
      gcts_pkg::ST_E_CHK: state_d = sts_i.full ? gcts_pkg::ST_DONE : gcts_pkg::ST_E_WRB;
      gcts_pkg::ST_E_WRB: state_d = gcts_pkg::ST_DONE;
      gcts_pkg::ST_R_RD:  state_d = gcts_pkg::ST_DONE;
      gcts_pkg::ST_P_CLR: if (sts_i.sweep_end) state_d = gcts_pkg::ST_P_VTX;
      gcts_pkg::ST_P_VTX:
        state_d = sts_i.i_end ? gcts_pkg::ST_P_FIN : gcts_pkg::ST_P_VTX2;
      gcts_pkg::ST_P_VTX2: state_d = gcts_pkg::ST_P_NB;
      gcts_pkg::ST_P_NB:
        state_d = sts_i.k_end ? gcts_pkg::ST_P_VTX : gcts_pkg::ST_P_NB2;
      gcts_pkg::ST_P_NB2:
        state_d = sts_i.u_out ? gcts_pkg::ST_P_NB : gcts_pkg::ST_P_NB3;
      gcts_pkg::ST_P_NB3: state_d = gcts_pkg::ST_P_NB4;
      gcts_pkg::ST_P_NB4: state_d = gcts_pkg::ST_P_NB;
      gcts_pkg::ST_P_FIN: state_d = gcts_pkg::ST_DONE;
      gcts_pkg::ST_I_START: state_d = gcts_pkg::ST_I_VTX;
      gcts_pkg::ST_I_VTX:
        state_d = sts_i.i_end ? gcts_pkg::ST_I_DECIDE : gcts_pkg::ST_I_VTX2;
      gcts_pkg::ST_I_VTX2: state_d = gcts_pkg::ST_I_VTX3;
      gcts_pkg::ST_I_VTX3:
        state_d = sts_i.here_zero ? gcts_pkg::ST_I_VTX : gcts_pkg::ST_I_COL;
      gcts_pkg::ST_I_COL: begin
        if (sts_i.j_end) begin
          state_d = gcts_pkg::ST_I_VTX;
        end else if (!sts_i.j_is_ci) begin
          state_d = gcts_pkg::ST_I_COL2;
        end
      end
      gcts_pkg::ST_I_COL2: state_d = gcts_pkg::ST_I_COL;
      gcts_pkg::ST_I_DECIDE:
        state_d = sts_i.no_move ? gcts_pkg::ST_DONE : gcts_pkg::ST_I_MOD;
      gcts_pkg::ST_I_MOD: if (sts_i.mod_end) state_d = gcts_pkg::ST_I_TIE;
      gcts_pkg::ST_I_TIE:   state_d = gcts_pkg::ST_I_TIE2;
      gcts_pkg::ST_I_TIE2:  state_d = gcts_pkg::ST_I_APPLY;
      gcts_pkg::ST_I_APPLY: state_d = gcts_pkg::ST_I_TABU;
      gcts_pkg::ST_I_TABU:  state_d = gcts_pkg::ST_I_TABU2;
      gcts_pkg::ST_I_TABU2: state_d = gcts_pkg::ST_I_NB;
      gcts_pkg::ST_I_NB:
        state_d = sts_i.k_end ? gcts_pkg::ST_DONE : gcts_pkg::ST_I_NB2;
      gcts_pkg::ST_I_NB2:
        state_d = sts_i.u_out ? gcts_pkg::ST_I_NB : gcts_pkg::ST_I_NB3;
      gcts_pkg::ST_I_NB3: state_d = gcts_pkg::ST_I_NB4;
      gcts_pkg::ST_I_NB4: state_d = gcts_pkg::ST_I_NB5;
      gcts_pkg::ST_I_NB5: state_d = gcts_pkg::ST_I_NB;
      gcts_pkg::ST_DONE: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d = gcts_pkg::ST_IDLE;
        end
      end
      default: state_d = gcts_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> src/gcts_datapath.sv
`timescale 1ns / 1ps
// graph memories, count and tabu tables, tie lists, counters and arithmetic
// depends on gcts_pkg, driven by gcts_ctrl
module gcts_datapath #(
  parameter int MaxV = gcts_pkg::MAX_VERTICES,
  parameter int MaxC = gcts_pkg::MAX_COLORS,
  parameter int MaxT = gcts_pkg::MAX_TIES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gcts_pkg::cmd_t         cmd_i,
  input  logic [gcts_pkg::IN_W-1:0] in_data_i,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [9:0]             cfg_data_i,
  output gcts_pkg::sts_t         sts_o,
  output gcts_pkg::res_t         res_o
);

  localparam int VW       = $clog2(MaxV);
  localparam int NW       = $clog2(MaxV + 1);
  localparam int CW       = $clog2(MaxC);
  localparam int KW       = $clog2(MaxC + 1);
  localparam int LW       = $clog2(MaxT);
  localparam int TW       = $clog2(MaxT + 1);
  localparam int NL_DEPTH = MaxV * MaxV;
  localparam int NLAW     = $clog2(NL_DEPTH);
  localparam int CC_DEPTH = MaxV * MaxC;
  localparam int CCAW     = $clog2(CC_DEPTH);
  localparam int TWW      = 2 * NW + 1;
  localparam int TEW      = VW + CW;
  localparam int CFW      = gcts_pkg::CONFLICT_W;
  localparam int CNW      = gcts_pkg::COUNT_W;

  function automatic logic [CCAW-1:0] cc_addr(logic [VW-1:0] v, logic [CW-1:0] c);
    return CCAW'(v) * CCAW'(MaxC) + CCAW'(c);
  endfunction

  function automatic logic [NLAW-1:0] nl_addr(logic [VW-1:0] v, logic [NW-1:0] k);
    return NLAW'(v) * NLAW'(MaxV) + NLAW'(k);
  endfunction

  // memories
  logic [VW-1:0]     nl_mem   [0:NL_DEPTH-1];
  logic [NW-1:0]     deg_mem  [0:MaxV-1];
  logic [CW-1:0]     col_mem  [0:MaxV-1];
  logic [CNW-1:0]    ncc_mem  [0:CC_DEPTH-1];
  logic [31:0]       tabu_mem [0:CC_DEPTH-1];
  logic [TEW-1:0]    ftie_mem [0:MaxT-1];
  logic [TEW-1:0]    ttie_mem [0:MaxT-1];

  logic [NLAW-1:0] nl_ra, nl_wa;
  logic [VW-1:0]   nl_rd, nl_wd;
  logic            nl_we;
  logic [VW-1:0]   deg_ra, deg_wa;
  logic [NW-1:0]   deg_rd, deg_wd;
  logic            deg_we;
  logic [VW-1:0]   col_ra, col_wa;
  logic [CW-1:0]   col_rd, col_wd;
  logic            col_we;
  logic [CCAW-1:0] ncc_ra, ncc_wa, tabu_ra, tabu_wa;
  logic [CNW-1:0]  ncc_rd, ncc_wd;
  logic            ncc_we, tabu_we;
  logic [31:0]     tabu_rd, tabu_wd;
  logic [LW-1:0]   tie_ra, tie_wa;
  logic [TEW-1:0]  ftie_rd, ttie_rd, tie_wd;
  logic            ftie_we, ttie_we;

  always_ff @(posedge clk_i) begin
    if (nl_we) nl_mem[nl_wa] <= nl_wd;
    nl_rd <= nl_mem[nl_ra];
  end
  always_ff @(posedge clk_i) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_rd <= deg_mem[deg_ra];
  end
  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[col_wa] <= col_wd;
    col_rd <= col_mem[col_ra];
  end
  always_ff @(posedge clk_i) begin
    if (ncc_we) ncc_mem[ncc_wa] <= ncc_wd;
    ncc_rd <= ncc_mem[ncc_ra];
  end
  always_ff @(posedge clk_i) begin
    if (tabu_we) tabu_mem[tabu_wa] <= tabu_wd;
    tabu_rd <= tabu_mem[tabu_ra];
  end
  always_ff @(posedge clk_i) begin
    if (ftie_we) ftie_mem[tie_wa] <= tie_wd;
    ftie_rd <= ftie_mem[tie_ra];
  end
  always_ff @(posedge clk_i) begin
    if (ttie_we) ttie_mem[tie_wa] <= tie_wd;
    ttie_rd <= ttie_mem[tie_ra];
  end

  // control registers
  logic [9:0]      vc_q;
  logic [6:0]      cc_q;
  logic [CFW-1:0]  conf_q, conf_d, best_q, best_d;
  logic [31:0]     iter_q, iter_d;
  logic [CCAW-1:0] s_q, s_d;

  // item registers
  logic [2:0]  mode_q;
  logic [8:0]  a_q, b_q;
  logic [5:0]  colv_q;
  logic [15:0] pick_q;
  logic [3:0]  ten_q;
  logic [1:0]  status_q;
  logic [8:0]  mv_q;
  logic [5:0]  mc_q, cout_q;
  logic [9:0]  md_q;

  // work registers
  logic [NW-1:0]        i_q, k_q, deg_q, da_q, db_q;
  logic [KW-1:0]        j_q;
  logic [CW-1:0]        ci_q, cu_q, c_q, old_q;
  logic [VW-1:0]        u_q, v_q;
  logic [CNW-1:0]       here_q;
  logic [TWW-1:0]       twice_q;
  logic signed [10:0]   bfree_q, btabu_q, delta_q;
  logic                 fok_q, tok_q, sel_tabu_q;
  logic [TW-1:0]        fn_q, tn_q, cnt_q, rem_q;
  logic [3:0]           bit_q;
  logic [31:0]          t1_q;

  logic [NW-1:0]  n;
  logic [KW-1:0]  kk;
  logic [31:0]    next_iter;
  logic signed [10:0] d;
  logic           is_free, f_new, f_app, t_new, t_app, take_tabu, bad;
  logic signed [18:0] aspire, nc;
  logic [TW:0]    trial, trial_sub;
  logic [32:0]    sum1, sum2;
  logic [3:0]     tadd;
  logic [TEW-1:0] tie_sel;

  always_comb begin
    n  = (vc_q > 10'(MaxV)) ? NW'(MaxV) : NW'(vc_q);
    kk = (16'(cc_q) > 16'(MaxC)) ? KW'(MaxC) : KW'(cc_q);
    next_iter = (iter_q == '1) ? iter_q : iter_q + 32'd1;
    d = $signed({1'b0, ncc_rd}) - $signed({1'b0, here_q});
    is_free = tabu_rd <= next_iter;
    f_new = is_free && (!fok_q || d < bfree_q);
    f_app = is_free && !f_new && d == bfree_q && fn_q < TW'(MaxT);
    t_new = !is_free && (!tok_q || d < btabu_q);
    t_app = !is_free && !t_new && d == btabu_q && tn_q < TW'(MaxT);
    aspire = 19'(best_q) - 19'(conf_q);
    take_tabu = tok_q && 19'(btabu_q) < aspire && (!fok_q || btabu_q < bfree_q);
    trial = {rem_q, pick_q[15]};
    trial_sub = trial - (TW+1)'(cnt_q);
    nc = 19'(conf_q) + 19'(delta_q);
    sum1 = 33'(iter_q) + 33'(conf_q);
    tadd = ((ten_q >= 4'(gcts_pkg::TENURE_SPAN)) ?
            ten_q - 4'(gcts_pkg::TENURE_SPAN) : ten_q) + 4'd1;
    sum2 = 33'(t1_q) + 33'(tadd);
    tie_sel = sel_tabu_q ? ttie_rd : ftie_rd;
    case (mode_q)
      gcts_pkg::MODE_LOAD_EDGE:
        bad = 16'(a_q) >= 16'(n) || 16'(b_q) >= 16'(n) || a_q == b_q;
      gcts_pkg::MODE_SET_COLOR: bad = 16'(a_q) >= 16'(n) || 16'(colv_q) >= 16'(kk);
      gcts_pkg::MODE_READ:      bad = 16'(a_q) >= 16'(n);
      default:                  bad = 1'b0;
    endcase
  end

  // status toward the sequencer
  always_comb begin
    sts_o.mode      = mode_q;
    sts_o.bad       = bad;
    sts_o.full      = da_q >= NW'(MaxV) || deg_rd >= NW'(MaxV);
    sts_o.sweep_end = s_q == CCAW'(CC_DEPTH - 1);
    sts_o.i_end     = i_q >= n;
    sts_o.k_end     = k_q >= deg_q;
    sts_o.u_out     = 16'(nl_rd) >= 16'(n);
    sts_o.here_zero = ncc_rd == '0;
    sts_o.j_end     = j_q >= kk;
    sts_o.j_is_ci   = j_q == KW'(ci_q);
    sts_o.no_move   = !take_tabu && !fok_q;
    sts_o.mod_end   = bit_q == 4'd15;
  end

  // memory ports
  always_comb begin
    nl_ra = '0; nl_wa = '0; nl_wd = '0; nl_we = 1'b0;
    deg_ra = '0; deg_wa = '0; deg_wd = '0; deg_we = 1'b0;
    col_ra = '0; col_wa = '0; col_wd = '0; col_we = 1'b0;
    ncc_ra = '0; ncc_wa = '0; ncc_wd = '0; ncc_we = 1'b0;
    tabu_ra = '0; tabu_wa = '0; tabu_wd = '0; tabu_we = 1'b0;
    tie_ra = rem_q[LW-1:0];
    tie_wa = '0; tie_wd = {VW'(i_q), CW'(j_q)};
    ftie_we = 1'b0; ttie_we = 1'b0;
    case (cmd_i.step)
      gcts_pkg::ST_INIT, gcts_pkg::ST_P_CLR: begin
        ncc_wa = s_q; ncc_we = 1'b1;
        tabu_wa = s_q; tabu_we = 1'b1;
        deg_wa = VW'(s_q);
        deg_we = (cmd_i.step == gcts_pkg::ST_INIT) && (32'(s_q) < 32'(MaxV));
      end
      gcts_pkg::ST_DISPATCH: begin
        deg_ra = VW'(a_q);
        col_wa = VW'(a_q); col_wd = CW'(colv_q);
        col_we = (mode_q == gcts_pkg::MODE_SET_COLOR) && !bad;
        col_ra = VW'(a_q);
      end
      gcts_pkg::ST_E_RDB: deg_ra = VW'(b_q);
      gcts_pkg::ST_E_CHK: begin
        nl_wa = nl_addr(VW'(a_q), da_q); nl_wd = VW'(b_q);
        nl_we = !sts_o.full;
        deg_wa = VW'(a_q); deg_wd = da_q + NW'(1); deg_we = !sts_o.full;
      end
      gcts_pkg::ST_E_WRB: begin
        nl_wa = nl_addr(VW'(b_q), db_q); nl_wd = VW'(a_q); nl_we = 1'b1;
        deg_wa = VW'(b_q); deg_wd = db_q + NW'(1); deg_we = 1'b1;
      end
      gcts_pkg::ST_P_VTX, gcts_pkg::ST_I_VTX: begin
        col_ra = VW'(i_q); deg_ra = VW'(i_q);
      end
      gcts_pkg::ST_P_NB:  nl_ra = nl_addr(VW'(i_q), k_q);
      gcts_pkg::ST_I_NB:  nl_ra = nl_addr(v_q, k_q);
      gcts_pkg::ST_P_NB2: col_ra = nl_rd;
      gcts_pkg::ST_P_NB3: ncc_ra = cc_addr(VW'(i_q), col_rd);
      gcts_pkg::ST_P_NB4: begin
        ncc_wa = cc_addr(VW'(i_q), cu_q); ncc_we = 1'b1;
        ncc_wd = (ncc_rd == gcts_pkg::COUNT_MAX) ? ncc_rd : ncc_rd + CNW'(1);
      end
      gcts_pkg::ST_I_VTX2: ncc_ra = cc_addr(VW'(i_q), col_rd);
      gcts_pkg::ST_I_COL: begin
        ncc_ra = cc_addr(VW'(i_q), CW'(j_q)); tabu_ra = cc_addr(VW'(i_q), CW'(j_q));
      end
      gcts_pkg::ST_I_COL2: begin
        tie_wa = is_free ? (f_new ? '0 : fn_q[LW-1:0]) : (t_new ? '0 : tn_q[LW-1:0]);
        ftie_we = f_new || f_app;
        ttie_we = t_new || t_app;
      end
      gcts_pkg::ST_I_TIE2: begin
        col_ra = tie_sel[TEW-1:CW]; deg_ra = tie_sel[TEW-1:CW];
      end
      gcts_pkg::ST_I_APPLY: begin
        col_wa = v_q; col_wd = c_q; col_we = 1'b1;
      end
      gcts_pkg::ST_I_TABU2: begin
        tabu_wa = cc_addr(v_q, old_q); tabu_we = 1'b1;
        tabu_wd = sum2[32] ? '1 : sum2[31:0];
      end
      gcts_pkg::ST_I_NB2: ncc_ra = cc_addr(nl_rd, old_q);
      gcts_pkg::ST_I_NB3: begin
        ncc_wa = cc_addr(u_q, old_q); ncc_we = 1'b1;
        ncc_wd = (ncc_rd == '0) ? ncc_rd : ncc_rd - CNW'(1);
      end
      gcts_pkg::ST_I_NB4: ncc_ra = cc_addr(u_q, c_q);
      gcts_pkg::ST_I_NB5: begin
        ncc_wa = cc_addr(u_q, c_q); ncc_we = 1'b1;
        ncc_wd = (ncc_rd == gcts_pkg::COUNT_MAX) ? ncc_rd : ncc_rd + CNW'(1);
      end
      default: ;
    endcase
  end

  // control register next values
  always_comb begin
    conf_d = conf_q;
    best_d = best_q;
    iter_d = iter_q;
    s_d    = s_q;
    case (cmd_i.step)
      gcts_pkg::ST_INIT, gcts_pkg::ST_P_CLR: s_d = sts_o.sweep_end ? '0 : s_q + CCAW'(1);
      gcts_pkg::ST_P_FIN: begin
        conf_d = (twice_q[TWW-1:1] > TWW'(gcts_pkg::CONFLICT_MAX)) ?
                 gcts_pkg::CONFLICT_MAX : CFW'(twice_q[TWW-1:1]);
        best_d = conf_d;
        iter_d = '0;
      end
      gcts_pkg::ST_I_APPLY: begin
        iter_d = next_iter;
        if (nc < 0) begin
          conf_d = '0;
        end else if (nc > 19'(gcts_pkg::CONFLICT_MAX)) begin
          conf_d = gcts_pkg::CONFLICT_MAX;
        end else begin
          conf_d = CFW'(nc);
        end
        if (conf_d < best_q) best_d = conf_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q   <= 10'd512;
      cc_q   <= 7'd64;
      conf_q <= '0;
      best_q <= '0;
      iter_q <= '0;
      s_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == gcts_pkg::CFG_VERTEX_COUNT) vc_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == gcts_pkg::CFG_COLOR_COUNT) cc_q <= cfg_data_i[6:0];
      conf_q <= conf_d;
      best_q <= best_d;
      iter_q <= iter_d;
      s_q    <= s_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.step)
      gcts_pkg::ST_IDLE: begin
        if (cmd_i.accept) begin
          mode_q   <= in_data_i[2:0];
          a_q      <= in_data_i[11:3];
          b_q      <= in_data_i[20:12];
          colv_q   <= in_data_i[26:21];
          pick_q   <= in_data_i[42:27];
          ten_q    <= in_data_i[46:43];
          status_q <= gcts_pkg::STATUS_OK;
          mv_q     <= '0;
          mc_q     <= '0;
          md_q     <= '0;
          cout_q   <= '0;
        end
      end
      gcts_pkg::ST_DISPATCH: if (bad) status_q <= gcts_pkg::STATUS_RANGE;
      gcts_pkg::ST_E_RDB: da_q <= deg_rd;
      gcts_pkg::ST_E_CHK: begin
        db_q <= deg_rd;
        if (sts_o.full) status_q <= gcts_pkg::STATUS_DEG_FULL;
      end
      gcts_pkg::ST_R_RD: cout_q <= 6'(col_rd);
      gcts_pkg::ST_P_CLR: begin
        i_q     <= '0;
        twice_q <= '0;
      end
      gcts_pkg::ST_P_VTX2: begin
        ci_q  <= col_rd;
        deg_q <= deg_rd;
        k_q   <= '0;
      end
      gcts_pkg::ST_P_NB, gcts_pkg::ST_I_NB: if (sts_o.k_end) i_q <= i_q + NW'(1);
      gcts_pkg::ST_P_NB2, gcts_pkg::ST_I_NB2: begin
        u_q <= nl_rd;
        k_q <= k_q + NW'(1);
      end
      gcts_pkg::ST_P_NB3: begin
        cu_q <= col_rd;
        if (col_rd == ci_q) twice_q <= twice_q + TWW'(1);
      end
      gcts_pkg::ST_I_START: begin
        i_q   <= '0;
        fok_q <= 1'b0;
        tok_q <= 1'b0;
        fn_q  <= '0;
        tn_q  <= '0;
      end
      gcts_pkg::ST_I_VTX2: ci_q <= col_rd;
      gcts_pkg::ST_I_VTX3: begin
        here_q <= ncc_rd;
        j_q    <= '0;
        if (sts_o.here_zero) i_q <= i_q + NW'(1);
      end
      gcts_pkg::ST_I_COL: begin
        if (sts_o.j_end) begin
          i_q <= i_q + NW'(1);
        end else if (sts_o.j_is_ci) begin
          j_q <= j_q + KW'(1);
        end
      end
      gcts_pkg::ST_I_COL2: begin
        j_q <= j_q + KW'(1);
        if (f_new) begin
          fok_q <= 1'b1; bfree_q <= d; fn_q <= TW'(1);
        end else if (f_app) begin
          fn_q <= fn_q + TW'(1);
        end
        if (t_new) begin
          tok_q <= 1'b1; btabu_q <= d; tn_q <= TW'(1);
        end else if (t_app) begin
          tn_q <= tn_q + TW'(1);
        end
      end
      gcts_pkg::ST_I_DECIDE: begin
        sel_tabu_q <= take_tabu;
        cnt_q      <= take_tabu ? tn_q : fn_q;
        delta_q    <= take_tabu ? btabu_q : bfree_q;
        rem_q      <= '0;
        bit_q      <= '0;
        if (sts_o.no_move) status_q <= gcts_pkg::STATUS_NO_MOVE;
      end
      gcts_pkg::ST_I_MOD: begin
        rem_q  <= (trial >= (TW+1)'(cnt_q)) ? TW'(trial_sub) : TW'(trial);
        pick_q <= {pick_q[14:0], 1'b0};
        bit_q  <= bit_q + 4'd1;
      end
      gcts_pkg::ST_I_TIE2: begin
        v_q <= tie_sel[TEW-1:CW];
        c_q <= tie_sel[CW-1:0];
      end
      gcts_pkg::ST_I_APPLY: begin
        old_q <= col_rd;
        deg_q <= deg_rd;
        k_q   <= '0;
        mv_q  <= 9'(v_q);
        mc_q  <= 6'(c_q);
        md_q  <= 10'(delta_q);
      end
      gcts_pkg::ST_I_TABU: t1_q <= sum1[32] ? '1 : sum1[31:0];
      default: ;
    endcase
  end

  always_comb begin
    res_o.status   = status_q;
    res_o.conflict = conf_q;
    res_o.best     = best_q;
    res_o.mv       = mv_q;
    res_o.mc       = mc_q;
    res_o.delta    = md_q;
    res_o.cout     = cout_q;
    res_o.solved   = conf_q == '0;
    res_o.iter     = iter_q;
  end

endmodule

>>> src/graph_coloring_tabu_search.sv
`timescale 1ns / 1ps
// prepare sweeps the count and tabu tables, then counts neighbour colors for every
// vertex; iterate scans every conflicting vertex and color, then updates the
// neighbours of the moved vertex, all through the single read port of the count
// table; one item at a time, next taken once its result is registered
// after reset a clearing pass over all MAX_VERTICES*MAX_COLORS addresses clears degree,
// count and tabu tables before the first item is taken
module graph_coloring_tabu_search #(
  parameter int MaxV = gcts_pkg::MAX_VERTICES,
  parameter int MaxC = gcts_pkg::MAX_COLORS,
  parameter int MaxT = gcts_pkg::MAX_TIES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // mode, vertex_a, vertex_b, color_value, random_pick, random_tenure
  input  logic [gcts_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // status, conflict, best_conflict, moved_vertex, moved_color, move_delta,
  // color_out, solved, iteration_count
  output logic [gcts_pkg::OUT_W-1:0] m_tdata,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [9:0]                 cfg_data_i
);

  gcts_pkg::cmd_t cmd;
  gcts_pkg::sts_t sts;
  gcts_pkg::res_t res;
  logic           m_valid_q, m_valid_d;
  logic [gcts_pkg::OUT_W-1:0] m_data_q;
  logic           out_free;

  assign out_free    = !m_valid_q || m_tready;
  assign cfg_ready_o = 1'b1;

  gcts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .s_tready_o (s_tready)
  );

  gcts_datapath #(
    .MaxV (MaxV),
    .MaxC (MaxC),
    .MaxT (MaxT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (s_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sts_o       (sts),
    .res_o       (res)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) m_data_q <= {4'b0, res};
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = m_data_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_valid_q || m_tready))
    else $error("result loaded over a pending result");

  a_solved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_data_q[67] == (m_data_q[18:2] == 17'd0)))
    else $error("solved flag disagrees with conflict count");

  a_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_data_q[35:19] <= m_data_q[18:2]))
    else $error("best conflict above current conflict");

endmodule

>>> tb/graph_coloring_tabu_search_test.sv
`timescale 1ns / 1ps
// self-checking bench for graph_coloring_tabu_search: directed table, star graph and single
// vertex cases, then random phases, every result checked against an in-bench predictor of the coloring search
// depends on gcts_pkg and the graph_coloring_tabu_search block
module graph_coloring_tabu_search_test;
  import gcts_pkg::*;

  localparam int IDLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    mode_e            mode;
    int unsigned      va;
    int unsigned      vb;
    int unsigned      col;
    int unsigned      pick;
    int unsigned      ten;
    bit               has_exp;
    status_e          exp_status;
    logic [5:0]       exp_color;
  } row_t;

  typedef struct {
    bit         has_exp;
    status_e    exp_status;
    logic [5:0] exp_color;
  } typed_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = CFG_VERTEX_COUNT;
  logic [9:0]        cfg_data_i = '0;

  graph_coloring_tabu_search DUT (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  bit [8:0]    nbr_list [MAX_VERTICES*MAX_VERTICES];
  int unsigned degree [MAX_VERTICES];
  bit [5:0]    vcolor [MAX_VERTICES];
  int unsigned color_hits [MAX_VERTICES*MAX_COLORS];
  bit [31:0]   tabu_end [MAX_VERTICES*MAX_COLORS];
  int unsigned free_ties [MAX_TIES];
  int unsigned tabu_ties [MAX_TIES];
  int unsigned conflicts, best_seen, iter_done;
  int unsigned vcount_reg = 512, ccount_reg = 64;

  res_t   expected_results [$];
  typed_t typed_checks [$];
  int     fail_count = 0;
  int     idle_cycles = 0;
  bit     hold_request = 1'b0;

  function automatic int unsigned vertices_used();
    return vcount_reg < MAX_VERTICES ? vcount_reg : MAX_VERTICES;
  endfunction

  function automatic int unsigned colors_used();
    return ccount_reg < MAX_COLORS ? ccount_reg : MAX_COLORS;
  endfunction

  function automatic bit [31:0] sat_add(input bit [31:0] a, input bit [31:0] b);
    bit [32:0] s;
    s = a + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void rebuild_counts();
    int unsigned n, twice, ci, u, cu;
    n = vertices_used();
    twice = 0;
    foreach (color_hits[x]) color_hits[x] = 0;
    foreach (tabu_end[x]) tabu_end[x] = '0;
    for (int unsigned i = 0; i < n; i++) begin
      ci = vcolor[i];
      for (int unsigned kk = 0; kk < degree[i] && kk < MAX_VERTICES; kk++) begin
        u = nbr_list[i*MAX_VERTICES + kk];
        if (u >= n) continue;
        cu = vcolor[u];
        if (cu == ci) twice++;
        if (color_hits[i*MAX_COLORS + cu] < COUNT_MAX) color_hits[i*MAX_COLORS + cu]++;
      end
    end
    conflicts = twice / 2;
    if (conflicts > CONFLICT_MAX) conflicts = CONFLICT_MAX;
    best_seen = conflicts;
    iter_done = 0;
  endfunction

  function automatic bit search_move(input int unsigned pick, input int unsigned ten,
                                     output int unsigned mv, output int unsigned mc,
                                     output int md);
    int unsigned n, k, next_iter, free_n, tabu_n, ci, code, v, c, old, u;
    int best_free, best_tabu, aspire, here, d, nc;
    bit free_ok, tabu_ok;
    n = vertices_used();
    k = colors_used();
    next_iter = sat_add(iter_done, 1);
    best_free = 0; best_tabu = 0; free_n = 0; tabu_n = 0;
    free_ok = 0; tabu_ok = 0;
    mv = 0; mc = 0; md = 0;
    aspire = int'(best_seen) - int'(conflicts);
    for (int unsigned i = 0; i < n; i++) begin
      ci = vcolor[i];
      here = color_hits[i*MAX_COLORS + ci];
      if (here <= 0) continue;
      for (int unsigned j = 0; j < k; j++) begin
        if (j == ci) continue;
        d = int'(color_hits[i*MAX_COLORS + j]) - here;
        code = i*MAX_COLORS + j;
        if (tabu_end[code] <= next_iter) begin
          if (!free_ok || d < best_free) begin
            free_ok = 1; best_free = d; free_n = 0;
          end
          if (d == best_free && free_n < MAX_TIES) begin
            free_ties[free_n] = code; free_n++;
          end
        end else begin
          if (!tabu_ok || d < best_tabu) begin
            tabu_ok = 1; best_tabu = d; tabu_n = 0;
          end
          if (d == best_tabu && tabu_n < MAX_TIES) begin
            tabu_ties[tabu_n] = code; tabu_n++;
          end
        end
      end
    end
    if (tabu_ok && best_tabu < aspire && (!free_ok || best_tabu < best_free)) begin
      md = best_tabu;
      code = tabu_ties[pick % tabu_n];
    end else if (free_ok) begin
      md = best_free;
      code = free_ties[pick % free_n];
    end else begin
      return 0;
    end
    iter_done = next_iter;
    nc = int'(conflicts) + md;
    if (nc < 0) nc = 0;
    if (nc > int'(CONFLICT_MAX)) nc = CONFLICT_MAX;
    conflicts = nc;
    if (conflicts < best_seen) best_seen = conflicts;
    v = code / MAX_COLORS;
    c = code % MAX_COLORS;
    old = vcolor[v];
    vcolor[v] = c;
    tabu_end[v*MAX_COLORS + old] = sat_add(sat_add(iter_done, conflicts), (ten % TENURE_SPAN) + 1);
    for (int unsigned e = 0; e < degree[v] && e < MAX_VERTICES; e++) begin
      u = nbr_list[v*MAX_VERTICES + e];
      if (u >= n) continue;
      if (color_hits[u*MAX_COLORS + old] > 0) color_hits[u*MAX_COLORS + old]--;
      if (color_hits[u*MAX_COLORS + c] < COUNT_MAX) color_hits[u*MAX_COLORS + c]++;
    end
    mv = v; mc = c;
    return 1;
  endfunction

  function automatic res_t predict_coloring_step(input logic [IN_W-1:0] d);
    res_t r;
    int unsigned a, b, col, n, mv, mc;
    int md;
    a = d[11:3]; b = d[20:12]; col = d[26:21];
    n = vertices_used();
    r = '0;
    r.status = STATUS_OK;
    case (d[2:0])
      MODE_LOAD_EDGE: begin
        if (a >= n || b >= n || a == b) r.status = STATUS_RANGE;
        else if (degree[a] >= MAX_VERTICES || degree[b] >= MAX_VERTICES)
          r.status = STATUS_DEG_FULL;
        else begin
          nbr_list[a*MAX_VERTICES + degree[a]] = b; degree[a]++;
          nbr_list[b*MAX_VERTICES + degree[b]] = a; degree[b]++;
        end
      end
      MODE_SET_COLOR: begin
        if (a >= n || col >= colors_used()) r.status = STATUS_RANGE;
        else vcolor[a] = col;
      end
      MODE_PREPARE: rebuild_counts();
      MODE_ITERATE: begin
        if (search_move(d[42:27], d[46:43], mv, mc, md)) begin
          r.mv = mv; r.mc = mc; r.delta = md;
        end else r.status = STATUS_NO_MOVE;
      end
      MODE_READ: begin
        if (a >= n) r.status = STATUS_RANGE;
        else r.cout = vcolor[a];
      end
      default: ;
    endcase
    r.conflict = conflicts;
    r.best = best_seen;
    r.solved = conflicts == 0;
    r.iter = iter_done;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    fail_count++;
  endtask

  // request and result monitors
  always @(posedge clk_i) begin
    res_t got, want;
    typed_t tc;
    if (rst_ni && s_tvalid && s_tready) expected_results.push_back(predict_coloring_step(s_tdata));
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata[$bits(res_t)-1:0];
      if (expected_results.size() == 0) report_mismatch("unexpected result", 0, 0);
      else begin
        want = expected_results.pop_front();
        tc = typed_checks.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.conflict != want.conflict) report_mismatch("conflict", got.conflict, want.conflict);
        if (got.best != want.best) report_mismatch("best_conflict", got.best, want.best);
        if (got.mv != want.mv) report_mismatch("moved_vertex", got.mv, want.mv);
        if (got.mc != want.mc) report_mismatch("moved_color", got.mc, want.mc);
        if (got.delta != want.delta) report_mismatch("move_delta", got.delta, want.delta);
        if (got.cout != want.cout) report_mismatch("color_out", got.cout, want.cout);
        if (got.solved != want.solved) report_mismatch("solved", got.solved, want.solved);
        if (got.iter != want.iter) report_mismatch("iteration_count", got.iter, want.iter);
        if (tc.has_exp && got.status != tc.exp_status)
          report_mismatch("listed status", got.status, tc.exp_status);
        if (tc.has_exp && got.cout != tc.exp_color)
          report_mismatch("listed color_out", got.cout, tc.exp_color);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // result receiver with random stalls and a long hold-off on request
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end
      stall = pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    end
  end

  task automatic send_request(input mode_e mode, input int unsigned va, input int unsigned vb,
                              input int unsigned col, input int unsigned pick,
                              input int unsigned ten, input typed_t tc);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    typed_checks.push_back(tc);
    s_tdata <= {1'b0, ten[3:0], pick[15:0], col[5:0], vb[8:0], va[8:0], mode};
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic send_plain(input mode_e mode, input int unsigned va, input int unsigned vb,
                            input int unsigned col);
    typed_t none;
    none = '{0, STATUS_OK, '0};
    send_request(mode, va, vb, col, $urandom_range(65535), $urandom_range(15), none);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_register(input logic index, input int unsigned value);
    drain();
    cfg_index_i <= index;
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (index == CFG_VERTEX_COUNT) vcount_reg = value & 10'h3FF;
    else ccount_reg = value & 7'h7F;
  endtask

  task automatic start_phase(input int unsigned vc, input int unsigned cc, input bit all_zero);
    write_register(CFG_VERTEX_COUNT, vc);
    write_register(CFG_COLOR_COUNT, cc);
    for (int unsigned v = 0; v < vertices_used(); v++)
      send_plain(MODE_SET_COLOR, v, 0, all_zero ? 0 : $urandom_range(colors_used() - 1));
  endtask

  row_t directed [] = '{
    '{MODE_SET_COLOR, 511, 0, 1, 0, 0, 1, STATUS_RANGE, 6'd0},
    '{MODE_SET_COLOR, 3, 0, 63, 0, 0, 1, STATUS_RANGE, 6'd0},
    '{MODE_SET_COLOR, 3, 0, 3, 0, 0, 1, STATUS_OK, 6'd0},
    '{MODE_READ, 3, 0, 0, 0, 0, 1, STATUS_OK, 6'd3},
    '{MODE_READ, 511, 0, 0, 0, 0, 1, STATUS_RANGE, 6'd0},
    '{MODE_LOAD_EDGE, 2, 2, 0, 0, 0, 1, STATUS_RANGE, 6'd0},
    '{MODE_LOAD_EDGE, 0, 511, 0, 0, 0, 1, STATUS_RANGE, 6'd0},
    '{MODE_ITERATE, 0, 0, 0, 0, 0, 1, STATUS_NO_MOVE, 6'd0},
    '{MODE_LOAD_EDGE, 0, 1, 0, 0, 0, 1, STATUS_OK, 6'd0},
    '{MODE_LOAD_EDGE, 1, 2, 0, 0, 0, 1, STATUS_OK, 6'd0},
    '{MODE_LOAD_EDGE, 0, 2, 0, 0, 0, 1, STATUS_OK, 6'd0},
    '{MODE_LOAD_EDGE, 19, 0, 0, 0, 0, 1, STATUS_OK, 6'd0},
    '{MODE_SET_COLOR, 0, 0, 0, 0, 0, 1, STATUS_OK, 6'd0},
    '{MODE_SET_COLOR, 1, 0, 0, 0, 0, 1, STATUS_OK, 6'd0},
    '{MODE_SET_COLOR, 2, 0, 0, 0, 0, 1, STATUS_OK, 6'd0},
    '{MODE_PREPARE, 0, 0, 0, 0, 0, 0, STATUS_OK, 6'd0},
    '{MODE_ITERATE, 0, 0, 0, 65535, 15, 0, STATUS_OK, 6'd0},
    '{MODE_ITERATE, 0, 0, 0, 0, 0, 0, STATUS_OK, 6'd0},
    '{MODE_ITERATE, 0, 0, 0, 12345, 9, 0, STATUS_OK, 6'd0},
    '{MODE_READ, 0, 0, 0, 0, 0, 0, STATUS_OK, 6'd0},
    '{mode_e'(3'd5), 511, 511, 63, 65535, 15, 1, STATUS_OK, 6'd0},
    '{mode_e'(3'd6), 0, 0, 0, 0, 0, 1, STATUS_OK, 6'd0},
    '{mode_e'(3'd7), 0, 0, 0, 0, 0, 1, STATUS_OK, 6'd0}
  };

  initial begin
    typed_t tc;
    int r;
    int unsigned n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    start_phase(20, 4, 0);
    foreach (directed[i]) begin
      tc = '{directed[i].has_exp, directed[i].exp_status, directed[i].exp_color};
      send_request(directed[i].mode, directed[i].va, directed[i].vb, directed[i].col,
                   directed[i].pick, directed[i].ten, tc);
    end

    // star graph at the largest sizes: degree full
    start_phase(1023, 127, 1);
    for (int unsigned e = 0; e < 514; e++) send_plain(MODE_LOAD_EDGE, 0, 1 + e % 511, 0);
    send_plain(MODE_PREPARE, 0, 0, 0);
    repeat (3) send_plain(MODE_ITERATE, 0, 0, 0);
    send_plain(MODE_READ, 511, 0, 0);

    // single vertex, two colors
    start_phase(1, 2, 0);
    send_plain(MODE_LOAD_EDGE, 0, 0, 0);
    send_plain(MODE_PREPARE, 0, 0, 0);
    send_plain(MODE_ITERATE, 0, 0, 0);

    for (int ph = 0; ph < 5; ph++) begin
      start_phase(ph == 4 ? 10 : $urandom_range(40, 4), ph == 4 ? 64 : $urandom_range(8, 2), 0);
      n = vertices_used();
      repeat (2 * n) send_plain(MODE_LOAD_EDGE, $urandom_range(n - 1), $urandom_range(n - 1), 0);
      send_plain(MODE_PREPARE, 0, 0, 0);
      if (ph == 2) hold_request = 1'b1;
      repeat (25) begin
        r = $urandom_range(99);
        if (r < 62) send_plain(MODE_ITERATE, 0, 0, 0);
        else if (r < 72) send_plain(MODE_READ, $urandom_range(n - 1), 0, 0);
        else if (r < 80) send_plain(MODE_SET_COLOR, $urandom_range(n - 1), 0, $urandom_range(63));
        else if (r < 87)
          send_plain(MODE_LOAD_EDGE, $urandom_range(n - 1), $urandom_range(n - 1), 0);
        else if (r < 91) send_plain(MODE_PREPARE, 0, 0, 0);
        else if (r < 95)
          send_plain(mode_e'($urandom_range(7, 5)), $urandom_range(511), $urandom_range(511),
                     $urandom_range(63));
        else send_plain(mode_e'($urandom_range(4)), $urandom_range(511), $urandom_range(511),
                        $urandom_range(63));
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
src/gcts_pkg.sv
src/gcts_ctrl.sv
src/gcts_datapath.sv
src/graph_coloring_tabu_search.sv
tb/graph_coloring_tabu_search_test.sv
